// ----- sv/bbidp_pkg.sv -----
// Shared types and constants for the burst balloons interval scoring block.
`default_nettype none

package bbidp_pkg;

  localparam int VALUE_W = 8;
  localparam int OUT_W = 30;
  localparam int OUTER_W = 2 * VALUE_W;
  localparam int PROD_W = 3 * VALUE_W;

  localparam logic [VALUE_W-1:0] PAD_VALUE = VALUE_W'(1);
  localparam logic [63:0] VALUE_CUBE_MAX = 64'd16581375;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD_LO,
    ST_PAD_HI,
    ST_SETUP,
    ST_OUTER,
    ST_LOOP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ----- sv/bbidp_if.sv -----
// Handshake channels for balloon value items and score result items.
`default_nettype none

interface bbidp_in_if;
  logic                            valid;
  logic                            ready;
  logic [bbidp_pkg::VALUE_W-1:0]   value;
  logic                            last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface bbidp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bbidp_pkg::OUT_W-1:0]   max_coins;

  modport source (output valid, output max_coins, input ready);
  modport sink (input valid, input max_coins, output ready);
endinterface

`default_nettype wire

// ----- sv/burst_balloons_interval_dp.sv -----
// Top level of the burst balloons interval scoring block with its sequencer and datapath.
// Value items are loaded while the sequencer is in its load state; the block then computes,
// its run time set by the one score-table loop over k, where the
// shared multiply and add-compare unit handles one k per cycle, pipelined two deep.
// The result item leaves from an output register once it is free; loading then resumes.
// Reset clears the sequencer, item count and valid flags; the memories are written before read.
`default_nettype none

module burst_balloons_interval_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  bbidp_in_if.sink          in_i,
  bbidp_out_if.source       out_o
);

  localparam int SPAN = MAX_ITEMS + 2;
  localparam int DEPTH = SPAN * SPAN;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = $clog2(SPAN);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(64'(MAX_ITEMS) * bbidp_pkg::VALUE_CUBE_MAX + 64'd1);
  localparam int VW = bbidp_pkg::VALUE_W;
  localparam int OW = bbidp_pkg::OUT_W;
  localparam int QW = bbidp_pkg::OUTER_W;
  localparam int PW = bbidp_pkg::PROD_W;

  bbidp_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cbase_q, cbase_d;
  logic [IW-1:0] n_q, n_d;
  logic [IW-1:0] s_q, s_d;
  logic [IW-1:0] e_q, e_d;
  logic [IW-1:0] k_q, k_d;
  logic [AW-1:0] sbase_q, sbase_d;
  logic [AW-1:0] kbase_q, kbase_d;
  logic [QW-1:0] outer_q, outer_d;
  logic [SW-1:0] best_q, best_d;
  logic          p1_valid_q, p1_valid_d;
  logic          p1_lempty_q, p1_lempty_d;
  logic          p1_rempty_q, p1_rempty_d;
  logic          p2_valid_q;
  logic [PW-1:0] prod_q;
  logic [SW-1:0] sum_q;
  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] out_data_q, out_data_d;

  logic [VW-1:0] vmem [SPAN];
  logic          vwe;
  logic [IW-1:0] vwaddr;
  logic [VW-1:0] vwdata;
  logic [IW-1:0] vra_addr, vrb_addr;
  logic [VW-1:0] vra_q, vrb_q;

  logic [SW-1:0] smem [DEPTH];
  logic          swe;
  logic [AW-1:0] swaddr;
  logic [AW-1:0] sra_addr, srb_addr;
  logic [SW-1:0] sra_q, srb_q;

  logic          in_fire;
  logic          room;
  logic          drained;
  logic          iv_last_e;
  logic          iv_last_s;
  logic          out_free;
  logic [SW-1:0] cand;

  assign in_fire   = in_i.valid && in_i.ready;
  assign room      = count_q < CW'(MAX_ITEMS);
  assign drained   = !p1_valid_q && !p2_valid_q;
  assign iv_last_e = e_q == n_q;
  assign iv_last_s = s_q == IW'(1);
  assign out_free  = !out_valid_q || out_o.ready;
  assign cand      = SW'(prod_q) + sum_q;

  assign in_i.ready      = state_q == bbidp_pkg::ST_LOAD;
  assign out_o.valid     = out_valid_q;
  assign out_o.max_coins = out_data_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbidp_pkg::ST_LOAD: begin
        if (in_fire && in_i.last) state_d = bbidp_pkg::ST_PAD_LO;
      end
      bbidp_pkg::ST_PAD_LO: state_d = bbidp_pkg::ST_PAD_HI;
      bbidp_pkg::ST_PAD_HI: state_d = bbidp_pkg::ST_SETUP;
      bbidp_pkg::ST_SETUP:  state_d = bbidp_pkg::ST_OUTER;
      bbidp_pkg::ST_OUTER:  state_d = bbidp_pkg::ST_LOOP;
      bbidp_pkg::ST_LOOP: begin
        if (k_q == e_q) state_d = bbidp_pkg::ST_DRAIN;
      end
      bbidp_pkg::ST_DRAIN: begin
        if (drained) begin
          state_d = (iv_last_e && iv_last_s) ? bbidp_pkg::ST_FINISH : bbidp_pkg::ST_SETUP;
        end
      end
      bbidp_pkg::ST_FINISH: begin
        if (out_free) state_d = bbidp_pkg::ST_LOAD;
      end
      default: state_d = bbidp_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    cbase_d     = cbase_q;
    n_d         = n_q;
    s_d         = s_q;
    e_d         = e_q;
    k_d         = k_q;
    sbase_d     = sbase_q;
    kbase_d     = kbase_q;
    outer_d     = outer_q;
    best_d      = best_q;
    p1_valid_d  = 1'b0;
    p1_lempty_d = p1_lempty_q;
    p1_rempty_d = p1_rempty_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    vwe         = 1'b0;
    vwaddr      = '0;
    vwdata      = bbidp_pkg::PAD_VALUE;
    vra_addr    = '0;
    vrb_addr    = '0;
    swe         = 1'b0;
    swaddr      = '0;
    sra_addr    = '0;
    srb_addr    = '0;

    if (p2_valid_q && cand > best_q) best_d = cand;

    unique case (state_q)
      bbidp_pkg::ST_LOAD: begin
        if (in_fire && room) begin
          vwe     = 1'b1;
          vwaddr  = IW'(count_q) + IW'(1);
          vwdata  = in_i.value;
          count_d = count_q + CW'(1);
          cbase_d = cbase_q + AW'(SPAN);
        end
        if (in_fire && in_i.last) begin
          n_d     = room ? IW'(count_q) + IW'(1) : IW'(count_q);
          sbase_d = room ? cbase_q + AW'(SPAN) : cbase_q;
          count_d = '0;
          cbase_d = '0;
        end
      end
      bbidp_pkg::ST_PAD_LO: begin
        vwe    = 1'b1;
        vwaddr = '0;
      end
      bbidp_pkg::ST_PAD_HI: begin
        vwe    = 1'b1;
        vwaddr = n_q + IW'(1);
        s_d    = n_q;
        e_d    = n_q;
      end
      bbidp_pkg::ST_SETUP: begin
        vra_addr = s_q - IW'(1);
        vrb_addr = e_q + IW'(1);
        k_d      = s_q;
        kbase_d  = sbase_q + AW'(SPAN);
        best_d   = '0;
      end
      bbidp_pkg::ST_OUTER: begin
        outer_d = QW'(vra_q) * QW'(vrb_q);
      end
      bbidp_pkg::ST_LOOP: begin
        vra_addr    = k_q;
        sra_addr    = sbase_q + AW'(k_q) - AW'(1);
        srb_addr    = kbase_q + AW'(e_q);
        p1_valid_d  = 1'b1;
        p1_lempty_d = k_q == s_q;
        p1_rempty_d = k_q == e_q;
        k_d         = k_q + IW'(1);
        kbase_d     = kbase_q + AW'(SPAN);
      end
      bbidp_pkg::ST_DRAIN: begin
        if (drained) begin
          swe    = 1'b1;
          swaddr = sbase_q + AW'(e_q);
          if (!iv_last_e) begin
            e_d = e_q + IW'(1);
          end else if (!iv_last_s) begin
            s_d     = s_q - IW'(1);
            e_d     = s_q - IW'(1);
            sbase_d = sbase_q - AW'(SPAN);
          end
        end
      end
      bbidp_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OW'(best_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbidp_pkg::ST_LOAD;
      count_q     <= '0;
      cbase_q     <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cbase_q     <= cbase_d;
      p1_valid_q  <= p1_valid_d;
      p2_valid_q  <= p1_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    s_q         <= s_d;
    e_q         <= e_d;
    k_q         <= k_d;
    sbase_q     <= sbase_d;
    kbase_q     <= kbase_d;
    outer_q     <= outer_d;
    best_q      <= best_d;
    p1_lempty_q <= p1_lempty_d;
    p1_rempty_q <= p1_rempty_d;
    prod_q      <= PW'(outer_q) * PW'(vra_q);
    sum_q       <= (p1_lempty_q ? '0 : sra_q) + (p1_rempty_q ? '0 : srb_q);
    out_data_q  <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwaddr] <= vwdata;
    vra_q <= vmem[vra_addr];
    vrb_q <= vmem[vrb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) smem[swaddr] <= best_q;
    sra_q <= smem[sra_addr];
    srb_q <= smem[srb_addr];
  end

  a_write_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swe |-> (!p1_valid_q && !p2_valid_q))
    else $error("Score written while products are still in flight.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("Item count exceeds the capacity.");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bbidp_pkg::ST_FINISH))
    else $error("Result item posted outside the finish step.");

  a_k_in_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbidp_pkg::ST_LOOP) |-> (k_q >= s_q && k_q <= e_q))
    else $error("Split position left its interval.");

endmodule

`default_nettype wire

// ----- verif/tb_burst_balloons_interval_dp.sv -----
// Testbench for the burst balloons interval scoring block with random and directed sequences.
`timescale 1ns / 100ps

module tb_burst_balloons_interval_dp;

  localparam int MAX_ITEMS = 64;
  localparam int ITEM_TARGET = 650;
  localparam int STALL_LIMIT = 250000;

  typedef struct packed {
    logic [bbidp_pkg::VALUE_W-1:0] value;
    logic                          last;
    logic                          hold;
  } balloon_item_t;

  typedef enum int {SEQ_RANDOM, SEQ_EXTREME, SEQ_ALL_MAX} seq_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bbidp_in_if  in_if ();
  bbidp_out_if out_if ();

  burst_balloons_interval_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  balloon_item_t                  balloon_queue[$];
  logic [bbidp_pkg::OUT_W-1:0]    expected_coins[$];
  logic [bbidp_pkg::VALUE_W-1:0]  padded_vals[0:MAX_ITEMS+1];
  logic [63:0]                    interval_best[0:MAX_ITEMS+1][0:MAX_ITEMS+1];
  int                             loaded_cnt = 0;
  int                             queued_cnt = 0;
  int                             items_in = 0;
  int                             idle_cycles = 0;
  int                             mismatch_count = 0;
  logic                           in_taken = 1'b0;
  logic                           calm;

  assign calm = (items_in >= 300) && (items_in < 420);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [bbidp_pkg::OUT_W-1:0] best_burst_score(input int n);
    logic [63:0] top;
    logic [63:0] outer;
    logic [63:0] cand;
    padded_vals[0] = bbidp_pkg::PAD_VALUE;
    padded_vals[n+1] = bbidp_pkg::PAD_VALUE;
    for (int s = n; s >= 1; s--) begin
      for (int e = s; e <= n; e++) begin
        top = 64'd0;
        outer = 64'(padded_vals[s-1]) * 64'(padded_vals[e+1]);
        for (int k = s; k <= e; k++) begin
          cand = outer * 64'(padded_vals[k])
               + ((k > s) ? interval_best[s][k-1] : 64'd0)
               + ((k < e) ? interval_best[k+1][e] : 64'd0);
          if (cand > top) top = cand;
        end
        interval_best[s][e] = top;
      end
    end
    return interval_best[1][n][bbidp_pkg::OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [bbidp_pkg::OUT_W-1:0] got,
                                 input logic [bbidp_pkg::OUT_W-1:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_item(input logic [bbidp_pkg::VALUE_W-1:0] value, input logic last,
                          input logic hold);
    balloon_item_t item;
    item.value = value;
    item.last = last;
    item.hold = hold;
    balloon_queue = {balloon_queue, item};
    queued_cnt++;
  endtask

  task automatic queue_sequence(input int len, input seq_kind_e kind, input logic hold);
    logic [bbidp_pkg::VALUE_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_ALL_MAX: begin
          v = '1;
        end
        SEQ_EXTREME: begin
          case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            2: v = bbidp_pkg::VALUE_W'(1);
            default: v = bbidp_pkg::VALUE_W'($urandom_range(0, 255));
          endcase
        end
        default: begin
          v = bbidp_pkg::VALUE_W'($urandom_range(0, 255));
        end
      endcase
      add_item(v, i == len - 1, hold && (i == 0));
    end
  endtask

  always @(negedge clk_i) begin : driver
    balloon_item_t nxt;
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (balloon_queue.size() != 0
            && !(balloon_queue[0].hold && expected_coins.size() != 0)
            && (calm || $urandom_range(0, 99) >= 15)) begin
          nxt = balloon_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.value <= nxt.value;
          in_if.last <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk_i) begin : monitor
    logic                        out_taken;
    logic [bbidp_pkg::OUT_W-1:0] want;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (in_taken) begin
        items_in++;
        if (loaded_cnt < MAX_ITEMS) begin
          loaded_cnt++;
          padded_vals[loaded_cnt] = in_if.value;
        end
        if (in_if.last) begin
          expected_coins = {expected_coins, best_burst_score(loaded_cnt)};
          loaded_cnt = 0;
        end
      end
      if (out_taken) begin
        if (expected_coins.size() == 0) begin
          report_mismatch("result with no sequence pending", out_if.max_coins, '0);
        end else begin
          want = expected_coins.pop_front();
          if (out_if.max_coins !== want) begin
            report_mismatch("max_coins", out_if.max_coins, want);
          end
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("burst_balloons_interval_dp: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int        seq_no;
    int        len;
    seq_kind_e kind;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;

    add_item(8'd0, 1'b1, 1'b0);
    add_item(8'd255, 1'b1, 1'b0);
    add_item(8'd255, 1'b0, 1'b0);
    add_item(8'd255, 1'b0, 1'b0);
    add_item(8'd255, 1'b1, 1'b0);
    add_item(8'd0, 1'b0, 1'b0);
    add_item(8'd255, 1'b0, 1'b0);
    add_item(8'd0, 1'b0, 1'b0);
    add_item(8'd255, 1'b1, 1'b0);
    add_item(8'd3, 1'b0, 1'b1);
    add_item(8'd1, 1'b0, 1'b0);
    add_item(8'd5, 1'b0, 1'b0);
    add_item(8'd8, 1'b1, 1'b0);
    add_item(8'd1, 1'b0, 1'b0);
    add_item(8'd0, 1'b1, 1'b0);
    add_item(8'd170, 1'b0, 1'b0);
    add_item(8'd85, 1'b1, 1'b0);

    seq_no = 0;
    while (queued_cnt < ITEM_TARGET) begin
      case (seq_no)
        4: begin
          queue_sequence(MAX_ITEMS, SEQ_ALL_MAX, 1'b0);
        end
        18: begin
          queue_sequence(MAX_ITEMS + 2, SEQ_RANDOM, 1'b1);
        end
        35: begin
          queue_sequence(MAX_ITEMS + 6, SEQ_EXTREME, 1'b0);
        end
        default: begin
          if ($urandom_range(0, 9) == 0) len = int'($urandom_range(13, 24));
          else len = int'($urandom_range(1, 12));
          kind = SEQ_RANDOM;
          if ($urandom_range(0, 3) == 0) kind = SEQ_EXTREME;
          queue_sequence(len, kind, $urandom_range(0, 11) == 0);
        end
      endcase
      seq_no++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (balloon_queue.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_coins.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("burst_balloons_interval_dp: match");
    end else begin
      $display("burst_balloons_interval_dp: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bbidp_pkg.sv
sv/bbidp_if.sv
sv/burst_balloons_interval_dp.sv
verif/tb_burst_balloons_interval_dp.sv
